// ===== rtl/bpma_pkg.sv =====
// ----------------------------------------------------------------------------
// bpma_pkg
// shared types and constants of the bearing pair moment accumulator
// ----------------------------------------------------------------------------
package bpma_pkg;

    localparam int NUM_W   = 6;   // weight matrices, also unique entries per matrix
    localparam int IDX_W   = 3;   // weight index width
    localparam int COUNT_W = 16;  // pair counter and min_pairs width

    localparam logic [COUNT_W-1:0] PAIR_MAX        = 16'hFFFF;
    localparam logic [COUNT_W-1:0] MIN_PAIRS_RESET = 16'd15;
    localparam logic [IDX_W-1:0]   LAST_IDX        = 3'd5;

    typedef logic [IDX_W-1:0] t_idx;
    typedef logic [1:0]       t_sel;

    // operand selects of the first bearing per weight: xx yy zz xy yz zx
    localparam t_sel W_SEL_P [NUM_W] = '{2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2};
    localparam t_sel W_SEL_Q [NUM_W] = '{2'd0, 2'd1, 2'd2, 2'd1, 2'd2, 2'd0};
    // operand selects of the second bearing per entry: 00 01 02 11 12 22
    localparam t_sel E_SEL_P [NUM_W] = '{2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd2};
    localparam t_sel E_SEL_Q [NUM_W] = '{2'd0, 2'd1, 2'd2, 2'd1, 2'd2, 2'd2};

    typedef struct packed {
        logic capture;  // input word taken this cycle
        logic issue;    // start a row pass
        logic load_e;   // form the outer product entries
        t_idx k;        // row of this pass
    } t_ctrl_cmd;

    typedef struct packed {
        logic adv;      // pipeline may move
    } t_ctrl_stat;

endpackage

// ===== rtl/bpma_ram.sv =====
// ----------------------------------------------------------------------------
// bpma_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
module bpma_ram #(
    parameter int WIDTH = 288,
    parameter int DEPTH = 6
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/bpma_ctrl.sv =====
// ----------------------------------------------------------------------------
// bpma_ctrl
// sequencer: takes a pair and runs six row passes through the datapath
// ----------------------------------------------------------------------------
module bpma_ctrl import bpma_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  t_ctrl_stat i_stat,
    output t_ctrl_cmd  o_cmd
);

    typedef enum logic {
        ST_IDLE,
        ST_BUSY
    } t_state;

    t_state r_state;
    t_idx   r_k;
    logic   ready;
    logic   accept;

    // a new pair may enter during the last pass of the previous one
    assign ready  = i_stat.adv && ((r_state == ST_IDLE) || (r_k == LAST_IDX));
    assign accept = i_s_axis_tvalid && ready;

    assign o_s_axis_tready = ready;
    assign o_cmd.capture   = accept;
    assign o_cmd.issue     = (r_state == ST_BUSY);
    assign o_cmd.load_e    = (r_state == ST_BUSY) && (r_k == '0);
    assign o_cmd.k         = r_k;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_k     <= '0;
        end else if (i_stat.adv) begin
            case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        r_state <= ST_BUSY;
                        r_k     <= '0;
                    end
                end
                ST_BUSY: begin
                    if (r_k == LAST_IDX) begin
                        r_k <= '0;
                        if (!accept) begin
                            r_state <= ST_IDLE;
                        end
                    end else begin
                        r_k <= r_k + 1'b1;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                    r_k     <= '0;
                end
            endcase
        end
    end

endmodule

// ===== rtl/bpma_dp.sv =====
// ----------------------------------------------------------------------------
// bpma_dp
// datapath: weight and entry products, sums memory, saturating row update
// ----------------------------------------------------------------------------
module bpma_dp import bpma_pkg::*; #(
    parameter int ACC_WIDTH    = 48,
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_ctrl_cmd                     i_cmd,
    output t_ctrl_stat                    o_stat,
    input  logic                          i_cfg_wr_en,
    input  logic [COUNT_W-1:0]            i_cfg_wr_data,
    input  logic [6*SAMPLE_WIDTH-1:0]     i_samples,
    input  logic                          i_final,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [NUM_W*ACC_WIDTH-1:0]    o_out_sums,
    output logic [COUNT_W-1:0]            o_out_total,
    output logic                          o_out_enough,
    output t_idx                          o_out_idx,
    output logic                          o_out_last
);

    localparam int S     = SAMPLE_WIDTH;
    localparam int F     = SAMPLE_WIDTH - 1;
    localparam int PW    = 2 * SAMPLE_WIDTH;
    localparam int WW    = SAMPLE_WIDTH + 1;
    localparam int TW    = 2 * WW;
    localparam int SUM_W = ((ACC_WIDTH > TW) ? ACC_WIDTH : TW) + 1;
    localparam int ROW_W = NUM_W * ACC_WIDTH;

    localparam logic signed [PW-1:0]    HALF    = {{(PW-F){1'b0}}, 1'b1, {(F-1){1'b0}}};
    localparam logic signed [SUM_W-1:0] ACC_MAX =
        {{(SUM_W-ACC_WIDTH+1){1'b0}}, {(ACC_WIDTH-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] ACC_MIN = ~ACC_MAX;

    // round half up of a Q1.F product back to F fraction bits
    function automatic logic signed [WW-1:0] round_mul(input logic signed [S-1:0] x,
                                                       input logic signed [S-1:0] y);
        logic signed [PW-1:0] p;
        logic signed [PW-1:0] q;
        p = x * y;
        q = (p + HALF) >>> F;
        return q[WW-1:0];
    endfunction

    // pair registers
    logic signed [S-1:0]  r_a [3];
    logic signed [S-1:0]  r_b [3];
    logic                 r_fin;
    logic [COUNT_W-1:0]   r_tot;
    logic                 r_en;
    logic [COUNT_W-1:0]   r_cnt;
    logic [COUNT_W-1:0]   r_min_pairs;
    logic [COUNT_W-1:0]   cnt_new;
    logic signed [WW-1:0] r_e [NUM_W];

    // stage 1: weight of the row
    logic                 r_s1_vld;
    t_idx                 r_s1_k;
    logic                 r_s1_fin;
    logic [COUNT_W-1:0]   r_s1_tot;
    logic                 r_s1_en;
    logic signed [WW-1:0] r_w;

    // stage 2: terms and old sums of the row
    logic                        r_s2_vld;
    t_idx                        r_s2_k;
    logic                        r_s2_fin;
    logic [COUNT_W-1:0]          r_s2_tot;
    logic                        r_s2_en;
    logic signed [TW-1:0]        r_term [NUM_W];
    logic signed [ACC_WIDTH-1:0] r_old [NUM_W];

    logic [NUM_W-1:0] r_rvld;
    logic [ROW_W-1:0] rdata;
    logic [ROW_W-1:0] new_row;
    logic             adv;
    logic             wr;

    // output register
    logic               r_out_vld;
    logic [ROW_W-1:0]   r_out_sums;
    logic [COUNT_W-1:0] r_out_tot;
    logic               r_out_en;
    t_idx               r_out_idx;
    logic               r_out_last;

    // hold everything while a result row finds the output register taken
    assign adv = !(r_s2_vld && r_s2_fin && r_out_vld && !i_out_ready);
    assign o_stat.adv = adv;
    assign wr = adv && r_s2_vld;

    assign cnt_new = (r_cnt == PAIR_MAX) ? r_cnt : r_cnt + 1'b1;

    always_comb begin
        logic signed [SUM_W-1:0] s;
        new_row = '0;
        for (int j = 0; j < NUM_W; j++) begin
            s = SUM_W'(r_old[j]) + SUM_W'(r_term[j]);
            if (s > ACC_MAX) begin
                s = ACC_MAX;
            end else if (s < ACC_MIN) begin
                s = ACC_MIN;
            end
            new_row[j*ACC_WIDTH +: ACC_WIDTH] = s[ACC_WIDTH-1:0];
        end
    end

    bpma_ram #(
        .WIDTH (ROW_W),
        .DEPTH (NUM_W)
    ) u_sums (
        .i_clk   (i_clk),
        .i_we    (wr),
        .i_waddr (r_s2_k),
        .i_wdata (new_row),
        .i_re    (adv && i_cmd.issue),
        .i_raddr (i_cmd.k),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_min_pairs <= MIN_PAIRS_RESET;
            r_s1_vld    <= 1'b0;
            r_s2_vld    <= 1'b0;
            r_rvld      <= '0;
            r_out_vld   <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_min_pairs <= i_cfg_wr_data;
            end
            if (i_cmd.capture) begin
                r_cnt <= i_final ? '0 : cnt_new;
            end
            if (adv) begin
                r_s1_vld <= i_cmd.issue;
                r_s2_vld <= r_s1_vld;
            end
            if (wr) begin
                r_rvld[r_s2_k] <= !r_s2_fin;
            end
            if (wr && r_s2_fin) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            for (int i = 0; i < 3; i++) begin
                r_a[i] <= i_samples[i*S +: S];
                r_b[i] <= i_samples[(3+i)*S +: S];
            end
            r_fin <= i_final;
            r_tot <= cnt_new;
            r_en  <= (cnt_new >= r_min_pairs);
        end
        if (adv) begin
            if (i_cmd.load_e) begin
                for (int j = 0; j < NUM_W; j++) begin
                    r_e[j] <= round_mul(r_b[E_SEL_P[j]], r_b[E_SEL_Q[j]]);
                end
            end
            r_w      <= round_mul(r_a[W_SEL_P[i_cmd.k]], r_a[W_SEL_Q[i_cmd.k]]);
            r_s1_k   <= i_cmd.k;
            r_s1_fin <= r_fin;
            r_s1_tot <= r_tot;
            r_s1_en  <= r_en;
            for (int j = 0; j < NUM_W; j++) begin
                r_term[j] <= r_w * r_e[j];
                r_old[j]  <= r_rvld[r_s1_k] ? rdata[j*ACC_WIDTH +: ACC_WIDTH] : '0;
            end
            r_s2_k   <= r_s1_k;
            r_s2_fin <= r_s1_fin;
            r_s2_tot <= r_s1_tot;
            r_s2_en  <= r_s1_en;
        end
        if (wr && r_s2_fin) begin
            r_out_sums <= new_row;
            r_out_tot  <= r_s2_tot;
            r_out_en   <= r_s2_en;
            r_out_idx  <= r_s2_k;
            r_out_last <= (r_s2_k == LAST_IDX);
        end
    end

    assign o_out_valid  = r_out_vld;
    assign o_out_sums   = r_out_sums;
    assign o_out_total  = r_out_tot;
    assign o_out_enough = r_out_en;
    assign o_out_idx    = r_out_idx;
    assign o_out_last   = r_out_last;

endmodule

// ===== rtl/bearing_pair_moment_accumulator_unit.sv =====
// ----------------------------------------------------------------------------
// bearing_pair_moment_accumulator_unit
// sums weighted outer products of matched bearing pairs, six matrices per set
// ----------------------------------------------------------------------------
// output: the result words of a set follow its last pair through the row
// pipeline, one result word per cycle while the sink is ready
// pairs: a new pair is taken only in the last of the six row passes of the one
// before, as they share the multiplier bank and the single row port of the sums memory
// reset: synchronous active low; clears the count, min_pairs to 15, and the
// row valid bits, so the sums read as zero at once (no clearing pass)
module bearing_pair_moment_accumulator_unit import bpma_pkg::*; #(
    parameter int ACC_WIDTH    = 48,
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    // configuration: min_pairs
    input  logic               i_cfg_wr_en,
    input  logic [COUNT_W-1:0] i_cfg_wr_data,
    // pair input
    input  logic i_s_axis_tvalid,
    output logic o_s_axis_tready,
    // first_x, first_y, first_z, second_x, second_y, second_z, zero pad
    input  logic [((6*SAMPLE_WIDTH+7)/8)*8-1:0] i_s_axis_tdata,
    input  logic i_s_axis_tlast,  // final_pair
    // result output
    output logic o_m_axis_tvalid,
    input  logic i_m_axis_tready,
    // sum_00, sum_01, sum_02, sum_11, sum_12, sum_22, pair_total, enough_pairs,
    // zero pad
    output logic [((NUM_W*ACC_WIDTH+COUNT_W+1+7)/8)*8-1:0] o_m_axis_tdata,
    output logic [IDX_W-1:0] o_m_axis_tuser,  // weight_index
    output logic o_m_axis_tlast               // last_result
);

    localparam int IN_BITS  = 6 * SAMPLE_WIDTH;
    localparam int OUT_BITS = NUM_W * ACC_WIDTH + COUNT_W + 1;
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

    t_ctrl_cmd                  cmd;
    t_ctrl_stat                 stat;
    logic [NUM_W*ACC_WIDTH-1:0] out_sums;
    logic [COUNT_W-1:0]         out_total;
    logic                       out_enough;

    // sequencer: takes a word, steps the row index 0..5
    bpma_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_stat          (stat),
        .o_cmd           (cmd)
    );

    // three-stage row pipeline: weight, products and old row, saturating update
    bpma_dp #(
        .ACC_WIDTH    (ACC_WIDTH),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_samples     (i_s_axis_tdata[IN_BITS-1:0]),
        .i_final       (i_s_axis_tlast),
        .o_out_valid   (o_m_axis_tvalid),
        .i_out_ready   (i_m_axis_tready),
        .o_out_sums    (out_sums),
        .o_out_total   (out_total),
        .o_out_enough  (out_enough),
        .o_out_idx     (o_m_axis_tuser),
        .o_out_last    (o_m_axis_tlast)
    );

    // pack result word, zero pad to whole bytes
    assign o_m_axis_tdata = OUT_W'({out_enough, out_total, out_sums});

endmodule

// ===== rtl/bpma_chk.sv =====
// ----------------------------------------------------------------------------
// bpma_chk
// port level checks of the bearing pair moment accumulator
// ----------------------------------------------------------------------------
module bpma_chk import bpma_pkg::*; #(
    parameter int ACC_WIDTH    = 48,
    parameter int SAMPLE_WIDTH = 16
) (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_s_axis_tvalid,
    input logic o_s_axis_tready,
    input logic [((6*SAMPLE_WIDTH+7)/8)*8-1:0] i_s_axis_tdata,
    input logic i_s_axis_tlast,
    input logic o_m_axis_tvalid,
    input logic i_m_axis_tready,
    input logic [((NUM_W*ACC_WIDTH+COUNT_W+1+7)/8)*8-1:0] o_m_axis_tdata,
    input logic [IDX_W-1:0] o_m_axis_tuser,
    input logic o_m_axis_tlast
);

    // pair word held by the source while it waits
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && !o_s_axis_tready |=>
            i_s_axis_tvalid && $stable(i_s_axis_tdata) && $stable(i_s_axis_tlast))
        else $error("pair word changed while waiting");

    // result word held while the sink stalls
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("result word changed while stalled");

    // last word of a set carries the last weight index
    a_last_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tlast == (o_m_axis_tuser == LAST_IDX)))
        else $error("tlast does not match weight index");

    // a taken pair occupies the sequencer for its row passes
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)
        else $error("pair accepted in consecutive cycles");

    // nothing to show right after reset
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid after reset");

endmodule

bind bearing_pair_moment_accumulator_unit bpma_chk #(
    .ACC_WIDTH    (ACC_WIDTH),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_bpma_chk (.*);

// ===== test/tb_bearing_pair_moment_accumulator_unit.sv =====
// ----------------------------------------------------------------------------
// tb_bearing_pair_moment_accumulator_unit
// self-checking bench for the bearing pair moment accumulator: a queue-fed
// driver streams bearing pairs, a predictor sums the weighted outer products
// of every accepted word, and a monitor checks each result word field by field
// ----------------------------------------------------------------------------
module tb_bearing_pair_moment_accumulator_unit;
    import bpma_pkg::*;

    localparam int ACC_WIDTH    = 48;
    localparam int SAMPLE_WIDTH = 16;
    localparam int FRAC         = SAMPLE_WIDTH - 1;   // fraction bits of a sample
    localparam int WEIGHT_W     = SAMPLE_WIDTH + 1;   // rounded products reach +2^FRAC
    localparam int IN_W         = ((6*SAMPLE_WIDTH+7)/8)*8;
    localparam int OUT_W        = ((NUM_W*ACC_WIDTH+COUNT_W+1+7)/8)*8;
    localparam int SUM_BITS     = NUM_W*ACC_WIDTH;

    localparam longint ACC_HI = (longint'(1) <<< (ACC_WIDTH-1)) - 1;
    localparam longint ACC_LO = -ACC_HI - 1;

    // back-to-back set with steady signs, all terms of one sign per sum
    localparam int LONG_SET      = 12;
    localparam int RAND_PHASES   = 4;
    localparam int RAND_PER_PHASE = 45;
    // a pair that closes no set may still be in the row passes when the queue drains
    localparam int SETTLE_CYCLES = 16;
    localparam int LIMIT_CYCLES  = 4_000_000;

    typedef struct packed {
        logic signed [5:0][SAMPLE_WIDTH-1:0] comp;  // f1 x y z then f2 x y z
        logic                                fin;   // final_pair
    } t_pair;

    typedef struct packed {
        t_idx                               widx;
        logic [NUM_W-1:0][ACC_WIDTH-1:0]    sums;
        logic [COUNT_W-1:0]                 total;
        logic                               enough;
        logic                               last;
    } t_moment_word;

    // ------------------------------------------------------------------------
    // block ports
    // ------------------------------------------------------------------------
    logic                 i_clk          = 1'b0;
    logic                 i_rst_n        = 1'b0;
    logic                 i_cfg_wr_en    = 1'b0;
    logic [COUNT_W-1:0]   i_cfg_wr_data  = '0;
    logic                 i_s_axis_tvalid = 1'b0;
    logic                 o_s_axis_tready;
    logic [IN_W-1:0]      i_s_axis_tdata;
    logic                 i_s_axis_tlast;
    logic                 o_m_axis_tvalid;
    logic                 i_m_axis_tready = 1'b0;
    logic [OUT_W-1:0]     o_m_axis_tdata;
    logic [IDX_W-1:0]     o_m_axis_tuser;
    logic                 o_m_axis_tlast;

    t_pair cur_pair = '0;   // word currently offered on the pair input

    // first_x, first_y, first_z, second_x, second_y, second_z from the lowest bit
    assign i_s_axis_tdata = IN_W'(cur_pair.comp);
    assign i_s_axis_tlast = cur_pair.fin;

    bearing_pair_moment_accumulator_unit #(
        .ACC_WIDTH    (ACC_WIDTH),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // bench state
    // ------------------------------------------------------------------------
    t_pair        pending_pairs [$];   // words waiting for the driver
    t_moment_word moments_due   [$];   // predicted result words, oldest first

    // predictor copy of the block state and of min_pairs
    longint             moment_acc [NUM_W*NUM_W];
    logic [COUNT_W-1:0] pair_count = '0;
    logic [COUNT_W-1:0] min_pairs_now = MIN_PAIRS_RESET;

    logic quiet = 1'b0;   // no idling on either side while set
    int   send_gap  = 0;
    int   stall_left = 0;
    int   errors = 0;
    int   pairs_taken = 0;
    int   words_checked = 0;
    int   sets_closed = 0;
    int   cfg_writes = 0;
    int   cycle_count = 0;

    // gap length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // q1.15 times q1.15, rounded half up back to q2.15
    function automatic logic signed [WEIGHT_W-1:0] q_product(
        input logic signed [SAMPLE_WIDTH-1:0] a,
        input logic signed [SAMPLE_WIDTH-1:0] b
    );
        longint p;
        p = longint'(a) * longint'(b) + (longint'(1) <<< (FRAC-1));
        return WEIGHT_W'(p >>> FRAC);
    endfunction

    // sums the six weighted outer products of one pair, closes the set on a final pair
    task automatic accumulate_pair(input t_pair p);
        logic signed [WEIGHT_W-1:0] wt  [NUM_W];
        logic signed [WEIGHT_W-1:0] ent [NUM_W];
        longint       s;
        t_moment_word r;
        // weights from f1: xx yy zz xy yz zx
        wt[0]  = q_product(p.comp[0], p.comp[0]);
        wt[1]  = q_product(p.comp[1], p.comp[1]);
        wt[2]  = q_product(p.comp[2], p.comp[2]);
        wt[3]  = q_product(p.comp[0], p.comp[1]);
        wt[4]  = q_product(p.comp[1], p.comp[2]);
        wt[5]  = q_product(p.comp[2], p.comp[0]);
        // unique outer product entries of f2: 00 01 02 11 12 22
        ent[0] = q_product(p.comp[3], p.comp[3]);
        ent[1] = q_product(p.comp[3], p.comp[4]);
        ent[2] = q_product(p.comp[3], p.comp[5]);
        ent[3] = q_product(p.comp[4], p.comp[4]);
        ent[4] = q_product(p.comp[4], p.comp[5]);
        ent[5] = q_product(p.comp[5], p.comp[5]);
        for (int k = 0; k < NUM_W; k++) begin
            for (int j = 0; j < NUM_W; j++) begin
                // terms stay below 2^31, so the 64-bit sum is exact before clamping
                s = moment_acc[k*NUM_W+j] + longint'(wt[k]) * longint'(ent[j]);
                if (s > ACC_HI) s = ACC_HI;
                if (s < ACC_LO) s = ACC_LO;
                moment_acc[k*NUM_W+j] = s;
            end
        end
        if (pair_count != PAIR_MAX) pair_count++;
        if (p.fin) begin
            for (int k = 0; k < NUM_W; k++) begin
                r.widx = t_idx'(k);
                for (int j = 0; j < NUM_W; j++)
                    r.sums[j] = moment_acc[k*NUM_W+j][ACC_WIDTH-1:0];
                r.total  = pair_count;
                r.enough = (pair_count >= min_pairs_now);
                r.last   = (t_idx'(k) == LAST_IDX);
                moments_due = {moments_due, r};
            end
            foreach (moment_acc[i]) moment_acc[i] = 0;
            pair_count = '0;
            sets_closed++;
        end
    endtask

    task automatic report_field(input string name, input logic [ACC_WIDTH-1:0] exp_v,
                                input logic [ACC_WIDTH-1:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch, expected %h actual %h", $time, name, exp_v, act_v);
            errors++;
        end
    endtask

    // ------------------------------------------------------------------------
    // pair driver: next word once the current one is taken, gaps in between
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else if (!i_s_axis_tvalid || o_s_axis_tready) begin
            if (send_gap > 0 && !quiet) begin
                send_gap--;
                i_s_axis_tvalid <= 1'b0;
            end else if (pending_pairs.size() > 0) begin
                cur_pair        <= pending_pairs.pop_front();
                i_s_axis_tvalid <= 1'b1;
                send_gap = pick_gap();
            end else begin
                i_s_axis_tvalid <= 1'b0;
            end
        end
    end

    // predictor runs on every accepted pair word
    always @(posedge i_clk) begin
        if (i_rst_n && i_s_axis_tvalid && o_s_axis_tready) begin
            accumulate_pair(cur_pair);
            pairs_taken++;
        end
    end

    // ------------------------------------------------------------------------
    // result sink: random stalls on tready
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else if (quiet) begin
            i_m_axis_tready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= 1'b1;
            if ($urandom_range(0, 99) < 30) stall_left = pick_gap();
        end
    end

    // result monitor: each accepted word against the oldest prediction
    always @(posedge i_clk) begin
        t_moment_word exp_w;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            words_checked++;
            if (moments_due.size() == 0) begin
                $display("%0t: result word with none expected, tuser %0d",
                         $time, o_m_axis_tuser);
                errors++;
            end else begin
                exp_w = moments_due.pop_front();
                report_field("weight_index", ACC_WIDTH'(exp_w.widx), ACC_WIDTH'(o_m_axis_tuser));
                for (int j = 0; j < NUM_W; j++)
                    report_field($sformatf("sum %0d of weight %0d", j, exp_w.widx),
                                 exp_w.sums[j], o_m_axis_tdata[j*ACC_WIDTH +: ACC_WIDTH]);
                report_field("pair_total", ACC_WIDTH'(exp_w.total),
                             ACC_WIDTH'(o_m_axis_tdata[SUM_BITS +: COUNT_W]));
                report_field("enough_pairs", ACC_WIDTH'(exp_w.enough),
                             ACC_WIDTH'(o_m_axis_tdata[SUM_BITS+COUNT_W]));
                report_field("last_result", ACC_WIDTH'(exp_w.last), ACC_WIDTH'(o_m_axis_tlast));
            end
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("%0t: run limit reached, %0d results outstanding", $time,
                     moments_due.size());
            $display("tb_bearing_pair_moment_accumulator_unit NOT OK");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    task automatic push_pair(input int ax, input int ay, input int az,
                             input int bx, input int by, input int bz, input logic fin);
        t_pair p;
        p.comp[0] = SAMPLE_WIDTH'(ax);
        p.comp[1] = SAMPLE_WIDTH'(ay);
        p.comp[2] = SAMPLE_WIDTH'(az);
        p.comp[3] = SAMPLE_WIDTH'(bx);
        p.comp[4] = SAMPLE_WIDTH'(by);
        p.comp[5] = SAMPLE_WIDTH'(bz);
        p.fin     = fin;
        pending_pairs = {pending_pairs, p};
    endtask

    // mostly full-range patterns, sometimes an extreme or a rounding edge
    function automatic int pick_component();
        case ($urandom_range(0, 11))
            0:       return -32768;
            1:       return 32767;
            2:       return 0;
            3:       return 16384;
            4:       return -1;
            default: return $urandom_range(0, 65535);
        endcase
    endfunction

    // wait until every word is sent and every result is in, then let the block settle
    task automatic wait_idle();
        do @(negedge i_clk);
        while (pending_pairs.size() != 0 || i_s_axis_tvalid || moments_due.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_min_pairs(input logic [COUNT_W-1:0] value);
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        min_pairs_now = value;
        cfg_writes++;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        @(negedge i_clk);
    endtask

    initial begin
        int len;
        int filled;
        logic [COUNT_W-1:0] phase_min;
        foreach (moment_acc[i]) moment_acc[i] = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed, min_pairs at its reset value of 15
        // one pair of opposite full-scale bearings, too few pairs
        push_pair(32767, 32767, 32767, -32768, -32768, -32768, 1'b1);
        // all zero pair
        push_pair(0, 0, 0, 0, 0, 0, 1'b1);
        // mixed extremes and round-half-up edges (products of exactly half an lsb)
        push_pair(-32768, 32767, 0, 32767, -32768, 1, 1'b0);
        push_pair(1, 16384, -16384, -1, 16384, 1, 1'b0);
        push_pair(-1, -1, 1, 16384, -16384, -32768, 1'b0);
        push_pair(32767, -32768, -32768, 0, 32767, -1, 1'b1);
        wait_idle();

        // lowest min_pairs: one pair is enough
        write_min_pairs('0);
        push_pair(-32768, -32768, -32768, 32767, 32767, 32767, 1'b1);
        wait_idle();

        // count right below and right at min_pairs
        write_min_pairs(COUNT_W'(5));
        for (int i = 0; i < 4; i++)
            push_pair(pick_component(), pick_component(), pick_component(),
                      pick_component(), pick_component(), pick_component(), i == 3);
        for (int i = 0; i < 5; i++)
            push_pair(pick_component(), pick_component(), pick_component(),
                      pick_component(), pick_component(), pick_component(), i == 4);
        wait_idle();

        // back-to-back set with steady signs and full-scale samples under the
        // highest min_pairs, so the set is never enough
        write_min_pairs(PAIR_MAX);
        quiet = 1'b1;
        for (int i = 0; i < LONG_SET; i++)
            push_pair(-32768, -32768, 32767, -32768, 32767, -32768, i == LONG_SET-1);
        wait_idle();
        quiet = 1'b0;

        // random sets under a few min_pairs settings, short sets mostly
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            case (ph)
                0:       phase_min = COUNT_W'($urandom_range(0, 16));
                1:       phase_min = COUNT_W'($urandom_range(0, 65535));
                2:       phase_min = COUNT_W'(1);
                default: phase_min = COUNT_W'($urandom_range(2, 10));
            endcase
            write_min_pairs(phase_min);
            filled = 0;
            while (filled < RAND_PER_PHASE) begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 30)
                                                  : $urandom_range(1, 12);
                for (int i = 0; i < len; i++)
                    push_pair(pick_component(), pick_component(), pick_component(),
                              pick_component(), pick_component(), pick_component(),
                              i == len-1);
                filled += len;
            end
            wait_idle();
        end

        $display("covered %0d pairs in %0d sets, %0d result words checked,",
                 pairs_taken, sets_closed, words_checked);
        $display("%0d min_pairs writes incl. 0 and 65535, back-to-back and stalled traffic",
                 cfg_writes);
        if (errors == 0) begin
            $display("tb_bearing_pair_moment_accumulator_unit OK");
        end else begin
            $display("tb_bearing_pair_moment_accumulator_unit NOT OK");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/bpma_pkg.sv
rtl/bpma_ram.sv
rtl/bpma_ctrl.sv
rtl/bpma_dp.sv
rtl/bearing_pair_moment_accumulator_unit.sv
rtl/bpma_chk.sv
test/tb_bearing_pair_moment_accumulator_unit.sv
